@@ src/vdit_pkg.sv @@
// Shared constants and helpers for the vertex deduplication index table.
package vdit_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Beat layout
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 9;
    localparam int POS_WORDS   = 4;
    localparam int VERT_W      = NUM_WORDS * WORD_W;
    localparam int POS_W       = POS_WORDS * WORD_W;
    localparam int SLOT_W      = 10;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register indexes (paddr[2] selects the word)
    localparam logic REG_MATCH_MODE = 1'b0;

    // Match modes
    localparam logic MODE_ALL_FIELDS = 1'b0;
    localparam logic MODE_POS_ONLY   = 1'b1;

    // Low SLOT_W bits of a table index
    function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] idx);
        logic [CNT_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

@@ src/vdit_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module vdit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/vertex_dedup_index_table.sv @@
// Vertex deduplication: linear search of a unique-vertex table held in one RAM.
// A hit on entry i returns slot i; a miss appends the vertex at slot entry_count, or
// reports overflow once the table is full. States IDLE, SEARCH, MISS and DONE feed a registered output.
// One vertex at a time: s_tready is high only in IDLE, and the search walks the
// single RAM read port over one stored entry per cycle.
// Reset (aresetn low, synchronous) empties the table and clears match_mode; no RAM sweep.
module vertex_dedup_index_table
    import vdit_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // vertex input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z, tex_u, tex_v (32 bits each)
    input  logic [VERT_W-1:0]      s_tdata,
    // index result
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // slot_index [9:0], zero fill [15:10]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // was_new [0], overflow [1]
    output logic [M_TUSER_W-1:0]   m_tuser
);

    // state codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [VERT_W-1:0]   vertex_reg;
    logic                mode_reg;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_new_reg, res_new_next;
    logic                res_ovf_reg, res_ovf_next;
    logic                m_valid_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic                m_new_reg;
    logic                m_ovf_reg;

    logic                s_beat;
    logic                cfg_wr;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [VERT_W-1:0]   ram_rdata;
    logic                pos_eq;
    logic                rest_eq;
    logic                hit;
    logic                last_entry;
    logic                out_free;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {{(APB_DATA_W-1){1'b0}}, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ALL_FIELDS;
        end else if (cfg_wr && paddr[2] == REG_MATCH_MODE) begin
            mode_reg <= pwdata[0];
        end
    end

    // vertex table
    vdit_ram #(
        .WIDTH (VERT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (vertex_reg),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // read one entry ahead of the compare
    assign ram_raddr = (state_reg == ST_SEARCH) ? cmp_idx_reg + 1'b1 : '0;
    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_we    = (state_reg == ST_MISS) && (count_reg != CNT_W'(TABLE_DEPTH));

    // entry compare
    assign pos_eq     = ram_rdata[POS_W-1:0] == vertex_reg[POS_W-1:0];
    assign rest_eq    = ram_rdata[VERT_W-1:POS_W] == vertex_reg[VERT_W-1:POS_W];
    assign hit        = pos_eq && (mode_reg == MODE_POS_ONLY || rest_eq);
    assign last_entry = ({{(CNT_W-IDX_W){1'b0}}, cmp_idx_reg} + 1'b1) == count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // search sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmp_idx_next  = cmp_idx_reg;
        res_slot_next = res_slot_reg;
        res_new_next  = res_new_reg;
        res_ovf_next  = res_ovf_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    cmp_idx_next = '0;
                    state_next   = (count_reg == '0) ? ST_MISS : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    res_slot_next = slot_of({{(CNT_W-IDX_W){1'b0}}, cmp_idx_reg});
                    res_new_next  = 1'b0;
                    res_ovf_next  = 1'b0;
                    state_next    = ST_DONE;
                end else if (last_entry) begin
                    state_next = ST_MISS;
                end else begin
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                end
            end
            ST_MISS: begin
                if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                    res_slot_next = '0;
                    res_new_next  = 1'b0;
                    res_ovf_next  = 1'b1;
                end else begin
                    res_slot_next = slot_of(count_reg);
                    res_new_next  = 1'b1;
                    res_ovf_next  = 1'b0;
                    count_next    = count_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        res_slot_reg <= res_slot_next;
        res_new_reg  <= res_new_next;
        res_ovf_reg  <= res_ovf_next;
        if (s_beat) begin
            vertex_reg <= s_tdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_slot_reg <= res_slot_reg;
            m_new_reg  <= res_new_reg;
            m_ovf_reg  <= res_ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-SLOT_W){1'b0}}, m_slot_reg};
    assign m_tuser  = {m_ovf_reg, m_new_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_accept_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> (state_reg == ST_SEARCH || state_reg == ST_MISS))
        else $error("accepted beat did not start a search");

    a_write_grows_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("table write without count increment");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0({m_ovf_reg, m_new_reg}))
        else $error("was_new and overflow both set");

    a_overflow_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ovf_reg) |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("overflow reported while table not full");

endmodule

@@ tb/vertex_dedup_index_table_test.sv @@
// Self-checking testbench for the vertex deduplication index table.
`timescale 1ns / 1ps

module vertex_dedup_index_table_test;
    import vdit_pkg::*;

    // byte addresses on the configuration port
    localparam logic [APB_ADDR_W-1:0] ADDR_MATCH_MODE = {REG_MATCH_MODE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE      = 3'b100;
    // m_tuser bits
    localparam int TUSER_NEW = 0;
    localparam int TUSER_OVF = 1;
    // run shape
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 50;
    localparam int STALL_LIMIT   = 8 * (TABLE_DEPTH + 8);

    // one vertex as it travels on s_tdata: pos_x ends up in the lowest word
    typedef struct packed {
        logic [WORD_W-1:0] tex_v;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] norm_z;
        logic [WORD_W-1:0] norm_y;
        logic [WORD_W-1:0] norm_x;
        logic [WORD_W-1:0] pos_w;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_x;
    } vertex_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              was_new;
        logic              overflow;
    } slot_result_t;

    typedef enum logic {ROW_VERTEX, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [APB_ADDR_W-1:0] addr;
        logic [APB_DATA_W-1:0] wdata;
        vertex_t               vert;
        logic                  has_want;
        slot_result_t          want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z, tex_u, tex_v (32 bits each)
    logic [VERT_W-1:0]     s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // slot_index [9:0], zero fill [15:10]
    logic [M_TDATA_W-1:0]  m_tdata;
    // was_new [0], overflow [1]
    logic [M_TUSER_W-1:0]  m_tuser;

    // predictor state
    vertex_t          vertex_table [TABLE_DEPTH];
    logic [CNT_W-1:0] stored_count = '0;
    logic             match_mode_q = MODE_ALL_FIELDS;

    slot_result_t expected_slots [$];
    vertex_t      sent_vertices [$];
    stim_row_t    stim_rows [$];
    slot_result_t head_result;
    int           errors       = 0;
    int           quiet_cycles = 0;
    int           stall_left   = 0;
    bit           idle_on      = 1'b0;

    vertex_dedup_index_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // first equal entry in insertion order, else append, else overflow
    function automatic slot_result_t dedup_lookup(input vertex_t v);
        slot_result_t     r;
        logic [VERT_W-1:0] probe;
        logic [VERT_W-1:0] cand;
        bit               hit;
        int               i;
        r     = '0;
        hit   = 1'b0;
        probe = v;
        for (i = 0; i < int'(stored_count) && !hit; i++) begin
            cand = vertex_table[i];
            if (cand[POS_W-1:0] == probe[POS_W-1:0] &&
                (match_mode_q == MODE_POS_ONLY || cand == probe)) begin
                r.slot = i[SLOT_W-1:0];
                hit    = 1'b1;
            end
        end
        if (!hit) begin
            if (int'(stored_count) >= TABLE_DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                vertex_table[stored_count[IDX_W-1:0]] = v;
                r.slot       = stored_count[SLOT_W-1:0];
                r.was_new    = 1'b1;
                stored_count = stored_count + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic vertex_t vtx(input logic [WORD_W-1:0] px, py, pz, pw,
                                    input logic [WORD_W-1:0] nx, ny, nz, tu, tv);
        vertex_t v;
        v.pos_x  = px;
        v.pos_y  = py;
        v.pos_z  = pz;
        v.pos_w  = pw;
        v.norm_x = nx;
        v.norm_y = ny;
        v.norm_z = nz;
        v.tex_u  = tu;
        v.tex_v  = tv;
        return v;
    endfunction

    function automatic stim_row_t vertex_row(input vertex_t v, input logic has_want,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic was_new, input logic overflow);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_VERTEX;
        row.vert     = v;
        row.has_want = has_want;
        row.want     = '{slot, was_new, overflow};
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [APB_ADDR_W-1:0] addr,
                                            input logic [APB_DATA_W-1:0] wdata);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.addr  = addr;
        row.wdata = wdata;
        return row;
    endfunction

    // append one row to the stimulus table
    function automatic void add_row(input stim_row_t row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // skewed towards zeros, signed zero and NaN patterns
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7F80_0000 | $urandom_range(1, 32'h007F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t fresh_vertex();
        return vtx(random_word(), random_word(), random_word(), random_word(),
                   random_word(), random_word(), random_word(), random_word(),
                   random_word());
    endfunction

    // new content in four of ten picks, else a repeat, often slightly altered
    function automatic vertex_t random_vertex();
        logic [VERT_W-1:0] flat;
        int                w;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick < 4 || sent_vertices.size() == 0)
            return fresh_vertex();
        flat = sent_vertices[$urandom_range(0, sent_vertices.size() - 1)];
        if (pick < 6) begin
            // alter a word that position-only matching ignores
            w = $urandom_range(POS_WORDS, NUM_WORDS - 1);
            flat[w*WORD_W +: WORD_W] = $urandom;
        end else if (pick < 8) begin
            w = $urandom_range(0, VERT_W - 1);
            flat[w] = ~flat[w];
        end
        return flat;
    endfunction

    // drive one vertex beat; valid stays high after acceptance
    task automatic offer_vertex(input vertex_t v, input logic has_want,
                                input slot_result_t want);
        slot_result_t got;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        do @(posedge aclk); while (!s_tready);
        got = dedup_lookup(v);
        sent_vertices.insert(sent_vertices.size(), v);
        expected_slots.insert(expected_slots.size(), has_want ? want : got);
    endtask

    // only once the table is idle; mode register is read back after a write to it
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] wdata);
        logic [APB_DATA_W-1:0] mode_word;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_slots.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_MATCH_MODE)
            match_mode_q = wdata[0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == ADDR_MATCH_MODE) begin
            mode_word = APB_DATA_W'(match_mode_q);
            @(negedge aclk);
            psel = 1'b1;
            @(negedge aclk);
            penable = 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata !== mode_word) begin
                $error("match_mode: expected %0h, got %0h", mode_word, prdata);
                errors++;
            end
            @(negedge aclk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    task automatic walk_rows();
        stim_row_t row;
        while (stim_rows.size() != 0) begin
            row = stim_rows.pop_front();
            if (row.kind == ROW_WRITE)
                write_register(row.addr, row.wdata);
            else
                offer_vertex(row.vert, row.has_want, row.want);
        end
    endtask

    // result side back-pressure in short bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready = 1'b1;
        end
    end

    // result check and activity count
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_slots.size() == 0) begin
                    $error("result beat with no vertex outstanding, slot_index %0d",
                           m_tdata[SLOT_W-1:0]);
                    errors++;
                end else begin
                    head_result = expected_slots.pop_front();
                    if (m_tdata[SLOT_W-1:0] !== head_result.slot) begin
                        $error("slot_index: expected %0d, got %0d",
                               head_result.slot, m_tdata[SLOT_W-1:0]);
                        errors++;
                    end
                    if (m_tuser[TUSER_NEW] !== head_result.was_new) begin
                        $error("was_new: expected %0b, got %0b",
                               head_result.was_new, m_tuser[TUSER_NEW]);
                        errors++;
                    end
                    if (m_tuser[TUSER_OVF] !== head_result.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               head_result.overflow, m_tuser[TUSER_OVF]);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: too long without any beat
    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        vertex_t va;
        vertex_t vb;
        vertex_t vn;
        vertex_t vone;
        int      phase;
        int      k;

        va   = vtx(0, 0, 0, 0, 0, 0, 0, 0, 0);
        vb   = vtx('1, '1, '1, '1, '1, '1, '1, '1, '1);
        vn   = vtx(32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000,
                   32'h7F80_0001, 32'hFFC0_0001, 32'h7FFF_FFFF, 32'hFF80_0000,
                   32'h7F80_0000);
        vone = vtx(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                   0, 0, 32'h3F80_0000, 0, 0);

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, hits, signed zero, NaN, both modes, spare address
        idle_on = 1'b1;
        add_row(vertex_row(va, 1, 10'd0, 1, 0));
        add_row(vertex_row(vb, 1, 10'd1, 1, 0));
        add_row(vertex_row(va, 1, 10'd0, 0, 0));
        add_row(vertex_row(vtx(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0),
                           1, 10'd2, 1, 0));
        add_row(vertex_row(vn, 1, 10'd3, 1, 0));
        add_row(vertex_row(vn, 1, 10'd3, 0, 0));
        add_row(vertex_row(vtx(0, 0, 0, 0, 0, 0, 32'h3F80_0000, 0, 0),
                           1, 10'd4, 1, 0));
        add_row(vertex_row(vtx(0, 0, 0, 0, 0, 0, 0, 32'h1, 0),
                           1, 10'd5, 1, 0));
        add_row(write_row(ADDR_MATCH_MODE, 32'h0000_0003));
        add_row(vertex_row(vtx(0, 0, 0, 0, 32'h1234_5678, 0, 0, 0, '1),
                           1, 10'd0, 0, 0));
        add_row(vertex_row(vtx('1, '1, '1, '1, 0, 0, 0, '1, '1),
                           1, 10'd1, 0, 0));
        add_row(write_row(ADDR_SPARE, 32'h0000_0000));
        add_row(vertex_row(vtx(32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000,
                               32'h7FC0_0000, 0, 0, 0, 0, 0),
                           1, 10'd3, 0, 0));
        add_row(vertex_row(vone, 1, 10'd6, 1, 0));
        add_row(write_row(ADDR_MATCH_MODE, 32'hFFFF_FFFE));
        add_row(vertex_row(vtx(0, 0, 0, 0, 0, 0, 32'h3F80_0000, 0, 0),
                           1, 10'd4, 0, 0));
        add_row(vertex_row(vtx(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                               32'h3F80_0000, 0, 0, 32'hBF80_0000, 0, 0),
                           1, 10'd7, 1, 0));
        add_row(vertex_row(vtx(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
                           0, '0, 0, 0));
        walk_rows();

        // random phases, each opened by a random write to the mode or spare address
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_on = (phase % 4 != 3);
            write_register(($urandom_range(0, 4) == 0) ? ADDR_SPARE : ADDR_MATCH_MODE,
                           $urandom);
            for (k = 0; k < PHASE_BEATS; k++)
                offer_vertex(random_vertex(), 0, '0);
        end

        // fill the table to the last slot, no idling from here on
        idle_on = 1'b0;
        write_register(ADDR_MATCH_MODE, APB_DATA_W'(MODE_ALL_FIELDS));
        while (int'(stored_count) < TABLE_DEPTH)
            offer_vertex(vtx($urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom), 0, '0);

        // full table: misses overflow, hits still resolve
        add_row(vertex_row(vtx(32'hDEAD_BEEF, 32'h0BAD_F00D, 1, 2, 3, 4, 5, 6, 7),
                           1, 10'd0, 0, 1));
        add_row(write_row(ADDR_MATCH_MODE, 32'h8000_0001));
        add_row(vertex_row(vtx(32'hDEAD_BEEF, 32'hFEED_FACE, 7, 6, 0, 0, 0, 0, 0),
                           1, 10'd0, 0, 1));
        add_row(vertex_row(vtx(0, 0, 0, 0, '1, '1, '1, '1, '1),
                           1, 10'd0, 0, 0));
        add_row(write_row(ADDR_MATCH_MODE, 32'h0000_0000));
        add_row(vertex_row(va, 1, 10'd0, 0, 0));
        add_row(vertex_row(vtx(0, 0, 0, 0, 0, 0, 0, 0, 32'h3F00_0000),
                           1, 10'd0, 0, 1));
        add_row(vertex_row(vertex_table[TABLE_DEPTH-1], 0, '0, 0, 0));
        add_row(vertex_row(vn, 1, 10'd3, 0, 0));
        walk_rows();

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_slots.size() != 0) @(posedge aclk);
        repeat (TABLE_DEPTH + 16) @(posedge aclk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
